>>> hdl/s2c_pkg.sv
// Package: types, coefficients and helpers for the spectral to sRGB color block.
`timescale 1ns / 1ps
`default_nettype none
package s2c_pkg;

  localparam int unsigned Bands      = 10;
  localparam int unsigned BandW      = 16;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CoefFrac   = 16;
  localparam int unsigned GammaBits  = 12;
  localparam int unsigned RomSize    = 1 << GammaBits;
  localparam int unsigned CoefW      = 18;
  localparam int unsigned ProdW      = BandW + CoefW;
  localparam int unsigned SumW       = ProdW + 4;
  localparam int unsigned NumW       = SumW + FracBits;
  localparam int unsigned DenW       = BandW + CoefFrac;
  localparam int unsigned QuoW       = NumW;
  localparam int unsigned XyzW       = 35;
  localparam int unsigned MatW       = 19;
  localparam int unsigned MacW       = XyzW + MatW + 3;
  localparam int unsigned VW         = FracBits + 1;
  localparam logic [63:0] LinDen     = 64'd10 << GammaBits;

  typedef struct packed {
    logic [BandW-1:0] band_405;
    logic [BandW-1:0] band_425;
    logic [BandW-1:0] band_450;
    logic [BandW-1:0] band_475;
    logic [BandW-1:0] band_515;
    logic [BandW-1:0] band_550;
    logic [BandW-1:0] band_555;
    logic [BandW-1:0] band_600;
    logic [BandW-1:0] band_640;
    logic [BandW-1:0] band_690;
    logic [BandW-1:0] clear_count;
  } req_t;

  typedef struct packed {
    logic [7:0] lin_red;
    logic [7:0] lin_green;
    logic [7:0] lin_blue;
    logic [7:0] srgb_red;
    logic [7:0] srgb_green;
    logic [7:0] srgb_blue;
  } rsp_t;

  typedef logic [CoefW-1:0] coef_t;

  function automatic coef_t cmf(input logic [1:0] c, input logic [3:0] k);
    coef_t x [Bands] = '{18'd1520, 18'd14075, 18'd22033, 18'd9313, 18'd1907,
                         18'd28407, 18'd33558, 18'd69612, 18'd29354, 18'd1488};
    coef_t y [Bands] = '{18'd42, 18'd478, 18'd2490, 18'd7379, 18'd39859,
                         18'd65205, 18'd65536, 18'd41353, 18'd11469, 18'd538};
    coef_t z [Bands] = '{18'd7222, 18'd68095, 18'd116137, 18'd68282, 18'd7320,
                         18'd573, 18'd377, 18'd52, 18'd1, 18'd0};
    coef_t r;
    case (c)
      2'd0:    r = x[k];
      2'd1:    r = y[k];
      default: r = z[k];
    endcase
    return r;
  endfunction

  function automatic logic signed [MatW-1:0] d65(input logic [1:0] r, input logic [1:0] c);
    logic signed [MatW-1:0] m [9] = '{19'sd212376, -19'sd100742, -19'sd32676,
                                      -19'sd63498, 19'sd122932, 19'sd2720,
                                      19'sd3650, -19'sd13369, 19'sd69272};
    return m[r*3+c];
  endfunction

  // Q0.32 truncating multiply
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[95:32];
  endfunction

  function automatic logic [63:0] gthr(input int unsigned c);
    logic [63:0] a, a2, a4, a8;
    a  = ((64'(40 * c + 561)) << 32) / 64'd10761;
    a2 = qmul(a, a);
    a4 = qmul(a2, a2);
    a8 = qmul(a4, a4);
    return qmul(a8, a4);
  endfunction

  function automatic logic [7:0] gentry(input int unsigned i);
    logic [63:0] l, l2, l5;
    int unsigned code;
    code = 0;
    if (64'(i) * 64'd10000000 <= (64'd31308 << GammaBits)) begin
      return 8'((64'd32946 * 64'(i)) / LinDen);
    end
    l  = 64'(i) << (32 - GammaBits);
    l2 = qmul(l, l);
    l5 = qmul(qmul(l2, l2), l);
    for (int unsigned c = 1; c < 255; c++) begin
      if (gthr(c) <= l5) code = c;
    end
    return 8'(code);
  endfunction

endpackage
`default_nettype wire

>>> hdl/s2c_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module s2c_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic [s2c_pkg::NumW-1:0]  num_i,
  input  wire logic [s2c_pkg::DenW-1:0]  den_i,
  output logic                           valid_o,
  output logic [s2c_pkg::QuoW-1:0]       quo_o
);
  import s2c_pkg::*;

  localparam int unsigned RemW = DenW + 1;

  logic                    vld_q [NumW];
  logic [NumW-1:0]         num_q [NumW];
  logic [DenW-1:0]         den_q [NumW];
  logic [RemW-1:0]         rem_q [NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic            vld_in;
    logic [NumW-1:0] num_in;
    logic [DenW-1:0] den_in;
    logic [RemW-1:0] rem_in;
    logic [RemW:0]   sh;
    logic [RemW:0]   df;
    logic [RemW-1:0] rem_d;
    logic [NumW-1:0] num_d;
    if (s == 0) begin : g_head
      assign vld_in = valid_i;
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
    end else begin : g_body
      assign vld_in = vld_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign rem_in = rem_q[s-1];
    end
    always_comb begin
      sh    = {rem_in, num_in[NumW-1]};
      df    = sh - {2'b00, den_in};
      num_d = {num_in[NumW-2:0], ~df[RemW]};
      rem_d = df[RemW] ? sh[RemW-1:0] : df[RemW-1:0];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      num_q[s] <= num_d;
      den_q[s] <= den_in;
      rem_q[s] <= rem_d;
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = num_q[NumW-1];
endmodule
`default_nettype wire

>>> hdl/s2c_lane.sv
// One color lane: weighted band sum and division for X, Y or Z.
`timescale 1ns / 1ps
`default_nettype none
module s2c_lane (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [1:0]                lane_i,
  input  wire logic                      valid_i,
  input  wire logic [s2c_pkg::BandW-1:0] band_i [s2c_pkg::Bands],
  input  wire logic [s2c_pkg::BandW-1:0] clear_i,
  output logic                           valid_o,
  output logic [s2c_pkg::XyzW-1:0]       xyz_o
);
  import s2c_pkg::*;

  logic [ProdW-1:0] prod_q [Bands];
  logic [BandW-1:0] clr_q, clr2_q;
  logic [SumW-1:0]  sum_q;
  logic             v1_q, v2_q;
  logic [SumW-1:0]  sum_d;
  logic [QuoW-1:0]  quo;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < Bands; k++) sum_d = sum_d + SumW'(prod_q[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Bands; k++) begin
      prod_q[k] <= ProdW'(band_i[k] * cmf(lane_i, 4'(k)));
    end
    clr_q  <= (clear_i == '0) ? BandW'(1) : clear_i;
    sum_q  <= sum_d;
    clr2_q <= clr_q;
  end

  s2c_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   ({sum_q, FracBits'(0)}),
    .den_i   ({clr2_q, CoefFrac'(0)}),
    .valid_o (valid_o),
    .quo_o   (quo)
  );

  // quotient is at most the full band sum with a clear count of one, below 2^35
  assign xyz_o = (|quo[QuoW-1:XyzW]) ? '1 : quo[XyzW-1:0];
endmodule
`default_nettype wire

>>> hdl/s2c_merge.sv
// Merge stage: matrix to linear RGB, clamp, scale and gamma lookup.
`timescale 1ns / 1ps
`default_nettype none
module s2c_merge (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic [s2c_pkg::XyzW-1:0] xyz_i [3],
  output logic                          valid_o,
  output s2c_pkg::rsp_t                 rsp_o
);
  import s2c_pkg::*;

  logic [7:0] rom [RomSize];
  always_comb begin
    for (int i = 0; i < RomSize; i++) rom[i] = gentry(i);
  end

  logic signed [MacW-1:0] prd_q [3][3];
  logic signed [MacW-1:0] acc_q [3];
  logic [VW-1:0]          v_q [3];
  logic [7:0]             lin_q [3];
  logic [7:0]             sg_q [3];
  logic [3:0]             vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      logic signed [MacW-1:0] a;
      logic [MacW-1:0]        sv;
      logic [VW+8-1:0]        m;
      logic [GammaBits-1:0]   ix;
      for (int c = 0; c < 3; c++) begin
        prd_q[r][c] <= MacW'(d65(2'(r), 2'(c))) * $signed({1'b0, xyz_i[c]});
      end
      a = prd_q[r][0] + prd_q[r][1] + prd_q[r][2];
      acc_q[r] <= a;
      sv = acc_q[r] >>> CoefFrac;
      if (acc_q[r] < 0) v_q[r] <= '0;
      else if (sv > MacW'(1 << FracBits)) v_q[r] <= VW'(1 << FracBits);
      else v_q[r] <= VW'(sv);
      m  = (VW+8)'(v_q[r]) * (VW+8)'(255);
      lin_q[r] <= m[FracBits +: 8];
      ix = v_q[r][FracBits] ? '1 : v_q[r][FracBits-1 -: GammaBits];
      sg_q[r] <= rom[ix];
    end
  end

  assign valid_o = vld_q[3];
  assign rsp_o = '{lin_red: lin_q[0], lin_green: lin_q[1], lin_blue: lin_q[2],
                   srgb_red: sg_q[0], srgb_green: sg_q[1], srgb_blue: sg_q[2]};
endmodule
`default_nettype wire

>>> hdl/spectral_to_srgb_color_top.sv
// Top level of the spectral to sRGB color converter.
// channel | ports                  | dir | timing
// request | start, req_i, busy      | in  | taken when start and !busy
// result  | done_o, rsp_o          | out | one cycle, strobe done_o
// One request per cycle; the path runs through 2 lane stages, 54 divider stages and 4 merge stages.
// The bit-serial divider pipeline in each lane sets the latency.
// Reset clears all valid bits; busy is always low.
// The receiver cannot stall; results are never held back.
`timescale 1ns / 1ps
`default_nettype none
module spectral_to_srgb_color_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire s2c_pkg::req_t  req_i,
  output logic                busy,
  output logic                done_o,
  output s2c_pkg::rsp_t       rsp_o
);
  import s2c_pkg::*;

  logic [BandW-1:0] bands [Bands];
  logic [2:0]       lv;
  logic [XyzW-1:0]  xyz [3];

  assign busy = 1'b0;
  assign bands = '{req_i.band_405, req_i.band_425, req_i.band_450, req_i.band_475,
                   req_i.band_515, req_i.band_550, req_i.band_555, req_i.band_600,
                   req_i.band_640, req_i.band_690};

  for (genvar l = 0; l < 3; l++) begin : g_lane
    s2c_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .lane_i  (2'(l)),
      .valid_i (start),
      .band_i  (bands),
      .clear_i (req_i.clear_count),
      .valid_o (lv[l]),
      .xyz_o   (xyz[l])
    );
  end

  s2c_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (&lv),
    .xyz_i   (xyz),
    .valid_o (done_o),
    .rsp_o   (rsp_o)
  );
endmodule
`default_nettype wire
